/* src/raa_pkg.sv */
// ----------------------------------------------------------------------------
// raa_pkg: shared types and codes of the rational accumulator ALU
// Operation codes, status codes and the one-hot sequencer state type.
// ----------------------------------------------------------------------------
package raa_pkg;

  // operation codes carried in s_axis_tuser
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_MUL  = 2'd3;

  // status codes carried in m_axis_tuser
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // sequencer states, one-hot
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MUL0  = 12'b0000_0000_0010,
    S_MUL1  = 12'b0000_0000_0100,
    S_MUL2  = 12'b0000_0000_1000,
    S_SUM   = 12'b0000_0001_0000,
    S_NORM  = 12'b0000_0010_0000,
    S_GCD   = 12'b0000_0100_0000,
    S_SCALE = 12'b0000_1000_0000,
    S_DIVN  = 12'b0001_0000_0000,
    S_DIVD  = 12'b0010_0000_0000,
    S_CHECK = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

endpackage

/* src/rational_accumulator_alu_core.sv */
// ----------------------------------------------------------------------------
// rational_accumulator_alu_core: exact fraction accumulator
// Applies load/add/subtract/multiply with an operand fraction, reduces the
// result by a binary gcd and a shared restoring divider, and reports it.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = operation, tdata = operand numerator/denominator.
//   Output stream: tdata = reduced accumulator num/den, tuser = status.
//   The accumulator is 0/1 after reset (rst_ni low, asynchronous).
//   One item is worked at a time; s_axis_tready is high only while the
//   sequencer idles. A zero operand denominator goes straight to the output
//   state. Otherwise: products in S_MUL0, S_MUL1 and S_MUL2 on one 33x33
//   multiplier (skipped for a load), sum and sign handling in S_SUM and
//   S_NORM, a binary gcd (one subtract or shift per cycle on one 64-bit
//   subtractor), S_SCALE to scale the gcd, then two restoring divisions
//   (numerator, then denominator) on the same subtractor, a check state and
//   an output state. A zero result skips the gcd and the divisions.
//   A result waits in the output register while the receiver stalls; the
//   next item may be taken meanwhile, and finishes once the register frees.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tuser: req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  // tdata: operand_num[31:0], operand_den[63:32]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: result_num[31:0], result_den[62:32], zero[63]
  output logic [63:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);
  import raa_pkg::*;

  localparam logic [63:0] Lim = 64'd1 << (VALUE_WIDTH - 1);

  state_e state_q, state_d;

  // accumulator
  logic signed [VALUE_WIDTH-1:0] acc_num_q, acc_num_d;
  logic [VALUE_WIDTH-2:0]        acc_den_q, acc_den_d;

  // item and working registers
  logic [1:0]         op_q, op_d;
  logic signed [31:0] c_q, c_d, d_q, d_d;
  logic signed [63:0] p0_q, p0_d, p1_q, p1_d, m_q, m_d;
  logic               neg_q, neg_d;
  logic [63:0]        mn_q, mn_d, md_q, md_d;
  logic [63:0]        u_q, u_d, v_q, v_d, g_q, g_d;
  logic [63:0]        rem_q, rem_d, quo_q, quo_d;
  logic [5:0]         k_q, k_d, cnt_q, cnt_d;
  logic [1:0]         status_q, status_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_num_q, out_num_d;
  logic [30:0]        out_den_q, out_den_d;
  logic [1:0]         out_status_q, out_status_d;

  // shared multiplier
  logic signed [32:0] a33, b33, c33, d33, mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] prod64;

  // shared subtractor
  logic [63:0] sub_a, sub_b, rem_sh, neg_diff, quo_sh;
  logic [64:0] sub_res;
  logic        borrow;

  // sum and sign handling
  logic signed [63:0] n_abs, m_abs;
  logic               ovf;

  assign a33 = 33'(acc_num_q);
  assign b33 = $signed({(34 - VALUE_WIDTH)'(0), acc_den_q});
  assign c33 = 33'(c_q);
  assign d33 = 33'(d_q);

  // multiplier operand select
  always_comb begin
    mul_a = b33;
    mul_b = d33;
    case (state_q)
      S_MUL0: begin
        mul_a = a33;
        mul_b = (op_q == OP_MUL) ? c33 : d33;
      end
      S_MUL1: begin
        mul_a = c33;
        mul_b = b33;
      end
      default: begin
        mul_a = b33;
        mul_b = d33;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod64 = $signed(prod[63:0]);

  // subtractor operand select: gcd step or divider step
  assign rem_sh = {rem_q[62:0], quo_q[63]};
  assign quo_sh = {quo_q[62:0], 1'b0};
  assign sub_a  = (state_q == S_GCD) ? u_q : rem_sh;
  assign sub_b  = (state_q == S_GCD) ? v_q : g_q;
  assign sub_res  = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = sub_res[64];
  assign neg_diff = ~sub_res[63:0] + 64'd1;

  assign n_abs = p0_q[63] ? -p0_q : p0_q;
  assign m_abs = m_q[63] ? -m_q : m_q;

  assign ovf = (neg_q ? (mn_q > Lim) : (mn_q > Lim - 64'd1)) || (md_q > Lim - 64'd1);

  // sequencer and datapath next state
  always_comb begin
    state_d      = state_q;
    acc_num_d    = acc_num_q;
    acc_den_d    = acc_den_q;
    op_d         = op_q;
    c_d          = c_q;
    d_d          = d_q;
    p0_d         = p0_q;
    p1_d         = p1_q;
    m_d          = m_q;
    neg_d        = neg_q;
    mn_d         = mn_q;
    md_d         = md_q;
    u_d          = u_q;
    v_d          = v_q;
    g_d          = g_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q;
    out_num_d    = out_num_q;
    out_den_d    = out_den_q;
    out_status_d = out_status_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = s_axis_tuser;
          c_d      = $signed(s_axis_tdata[31:0]);
          d_d      = $signed(s_axis_tdata[63:32]);
          status_d = ST_OK;
          if (s_axis_tdata[63:32] == 32'd0) begin
            status_d = ST_ZERO_DEN;
            state_d  = S_OUT;
          end else if (s_axis_tuser == OP_LOAD) begin
            state_d = S_SUM;
          end else begin
            state_d = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        p0_d    = prod64;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        p1_d    = prod64;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        m_d     = prod64;
        state_d = S_SUM;
      end
      // combine cross products, or take the operand for a load
      S_SUM: begin
        case (op_q)
          OP_LOAD: begin
            p0_d = 64'(c_q);
            m_d  = 64'(d_q);
          end
          OP_ADD:  p0_d = p0_q + p1_q;
          OP_SUB:  p0_d = p0_q - p1_q;
          default: p0_d = p0_q;
        endcase
        state_d = S_NORM;
      end
      // move sign into numerator, take magnitudes
      S_NORM: begin
        neg_d = (p0_q[63] ^ m_q[63]) && (p0_q != 64'sd0);
        if (p0_q == 64'sd0) begin
          mn_d    = 64'd0;
          md_d    = 64'd1;
          state_d = S_CHECK;
        end else begin
          mn_d    = n_abs;
          md_d    = m_abs;
          u_d     = n_abs;
          v_d     = m_abs;
          k_d     = 6'd0;
          state_d = S_GCD;
        end
      end
      // binary gcd, one step a cycle
      S_GCD: begin
        if (u_q == 64'd0) begin
          state_d = S_SCALE;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 6'd1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (!borrow) begin
          u_d = sub_res[63:0] >> 1;
        end else begin
          v_d = neg_diff >> 1;
        end
      end
      S_SCALE: begin
        g_d     = v_q << k_q;
        rem_d   = 64'd0;
        quo_d   = mn_q;
        cnt_d   = 6'd0;
        state_d = S_DIVN;
      end
      // restoring division steps, numerator then denominator
      S_DIVN, S_DIVD: begin
        if (borrow) begin
          rem_d = rem_sh;
          quo_d = quo_sh;
        end else begin
          rem_d = sub_res[63:0];
          quo_d = quo_sh | 64'd1;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          cnt_d = 6'd0;
          rem_d = 64'd0;
          if (state_q == S_DIVN) begin
            mn_d    = borrow ? quo_sh : (quo_sh | 64'd1);
            quo_d   = md_q;
            state_d = S_DIVD;
          end else begin
            md_d    = borrow ? quo_sh : (quo_sh | 64'd1);
            state_d = S_CHECK;
          end
        end
      end
      // range check and store
      S_CHECK: begin
        if (ovf) begin
          status_d = ST_OVERFLOW;
        end else begin
          acc_num_d = VALUE_WIDTH'(neg_q ? (64'd0 - mn_q) : mn_q);
          acc_den_d = (VALUE_WIDTH - 1)'(md_q);
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_num_d    = 32'(acc_num_q);
          out_den_d    = 31'(acc_den_q);
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      acc_num_q   <= '0;
      acc_den_q   <= (VALUE_WIDTH - 1)'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_num_q   <= acc_num_d;
      acc_den_q   <= acc_den_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    c_q          <= c_d;
    d_q          <= d_d;
    p0_q         <= p0_d;
    p1_q         <= p1_d;
    m_q          <= m_d;
    neg_q        <= neg_d;
    mn_q         <= mn_d;
    md_q         <= md_d;
    u_q          <= u_d;
    v_q          <= v_d;
    g_q          <= g_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    k_q          <= k_d;
    cnt_q        <= cnt_d;
    status_q     <= status_d;
    out_num_q    <= out_num_d;
    out_den_q    <= out_den_d;
    out_status_q <= out_status_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_den_q, out_num_q};
  assign m_axis_tuser  = out_status_q;

endmodule

/* dv/rational_accumulator_alu_core_tb.sv */
// ----------------------------------------------------------------------------
// rational_accumulator_alu_core_tb: self-checking bench for the fraction ALU
// Drives load/add/subtract/multiply items into the input stream, then checks
// every reply against its own exact fraction model. A directed set covers the
// extremes, zero denominators, overflow and zero results. A random set
// follows, with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_accumulator_alu_core_tb;
  import raa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          SETTLE_CYCLES = 400;

  localparam logic [31:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] V_MIN  = 32'h8000_0000;
  localparam logic [31:0] V_NEG1 = 32'hffff_ffff;

  typedef longint unsigned u64_t;

  // one expected reply
  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  status;
  } frac_t;

  // --------------------------------------------------------------------------
  // Tracks the accumulator and holds the replies still due
  // --------------------------------------------------------------------------
  class frac_acc_tracker;
    logic signed [31:0] acc_num;
    logic [30:0]        acc_den;
    frac_t              fracs_due[$];
    int                 mismatches;

    function new();
      acc_num    = 0;
      acc_den    = 1;
      mismatches = 0;
    endfunction

    function int pending();
      return fracs_due.size();
    endfunction

    // apply one accepted operand to the tracked accumulator
    function void take_operand(logic [1:0] op, logic [31:0] num_bits, logic [31:0] den_bits);
      longint c, d, a, b, n, m;
      u64_t   mag, dd, x, y, t;
      u64_t   lim;
      logic   neg;
      frac_t  e;
      lim = u64_t'(1) << 31;
      c = longint'($signed(num_bits));
      d = longint'($signed(den_bits));
      a = longint'(acc_num);
      b = longint'({1'b0, acc_den});
      e.status = ST_OK;
      if (d == 0) begin
        e.status = ST_ZERO_DEN;
      end else begin
        n = 0;
        m = 1;
        case (op)
          OP_LOAD: begin
            n = c;
            m = d;
          end
          OP_ADD: begin
            n = a * d + c * b;
            m = b * d;
          end
          OP_SUB: begin
            n = a * d - c * b;
            m = b * d;
          end
          OP_MUL: begin
            n = a * c;
            m = b * d;
          end
        endcase
        // sign goes to the numerator
        if (m < 0) begin
          n = -n;
          m = -m;
        end
        neg = (n < 0);
        mag = neg ? u64_t'(-n) : u64_t'(n);
        dd  = u64_t'(m);
        if (mag == 0) begin
          dd = 1;
        end else begin
          // Euclid
          x = mag;
          y = dd;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          mag = mag / x;
          dd  = dd / x;
        end
        if ((neg ? (mag > lim) : (mag > lim - 1)) || dd > lim - 1) begin
          e.status = ST_OVERFLOW;
        end else begin
          acc_num = neg ? 32'(-longint'(mag)) : 32'(mag);
          acc_den = 31'(dd);
        end
      end
      e.num = acc_num;
      e.den = acc_den;
      fracs_due.push_back(e);
    endfunction

    // compare one accepted reply with the oldest one due
    function void check_reply(logic [63:0] data, logic [1:0] user);
      frac_t e;
      if (fracs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected reply num=%0d den=%0d top=%b status=%0d", $realtime,
                   $signed(data[31:0]), data[62:32], data[63], user);
        return;
      end
      e = fracs_due.pop_front();
      if (data[31:0] !== e.num || data[62:32] !== e.den || data[63] !== 1'b0 ||
          user !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp num=%0d den=%0d top=0 status=%0d | got num=%0d den=%0d top=%b status=%0d",
                   $realtime, $signed(e.num), e.den, e.status,
                   $signed(data[31:0]), data[62:32], data[63], user);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic [1:0]  s_axis_tuser;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  bit              no_idle;
  int unsigned     cycle_count;
  frac_acc_tracker tracker;

  rational_accumulator_alu_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** rational_accumulator_alu_core: FAILED **");
      $finish;
    end
  end

  // monitor both streams at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      tracker.take_operand(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_reply(m_axis_tdata, m_axis_tuser);
  end

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [1:0] pick_op();
    if ($urandom_range(0, 99) < 15) return OP_LOAD;
    case ($urandom_range(0, 2))
      0:       return OP_ADD;
      1:       return OP_SUB;
      default: return OP_MUL;
    endcase
  endfunction

  // operand value: mostly small, some 16-bit, some full range, some extremes
  function automatic logic [31:0] pick_value(bit is_den);
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (is_den && r < 5) return 32'd0;
    if (r < 45)      v = is_den ? $urandom_range(1, 30) : $urandom_range(0, 30);
    else if (r < 70) v = $urandom_range(0, 65535);
    else if (r < 88) return $urandom;
    else begin
      case ($urandom_range(0, 4))
        0:       return 32'd0;
        1:       return 32'd1;
        2:       return V_NEG1;
        3:       return V_MAX;
        default: return V_MIN;
      endcase
    end
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // one input transfer, with an optional gap ahead of it
  task automatic send_item(logic [1:0] op, logic [31:0] num, logic [31:0] den);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {den, num};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender off until every reply has come back
  task automatic wait_drained();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: bursts of ready with random stalls
  initial begin
    int hi;
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hi = $urandom_range(1, 12);
      @(negedge clk_i) m_axis_tready <= 1'b1;
      repeat (hi - 1) @(negedge clk_i);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    tracker       = new();
    no_idle       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_LOAD;
    s_axis_tdata  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: basic ops, sign handling, zero denominators, zero results
    send_item(OP_ADD,  32'd1, 32'd2);
    send_item(OP_SUB,  32'd1, 32'd3);
    send_item(OP_MUL,  32'd3, -32'sd4);
    send_item(OP_LOAD, 32'd5, 32'd0);
    send_item(OP_ADD,  32'd7, 32'd0);
    send_item(OP_MUL,  32'd0, 32'd5);
    // extremes and overflow
    send_item(OP_LOAD, V_MAX, 32'd1);
    send_item(OP_ADD,  32'd1, 32'd1);
    send_item(OP_LOAD, V_MIN, 32'd1);
    send_item(OP_LOAD, V_MIN, V_NEG1);
    send_item(OP_SUB,  32'd1, 32'd1);
    send_item(OP_LOAD, 32'd1, V_MAX);
    send_item(OP_LOAD, 32'd1, V_MIN);
    send_item(OP_LOAD, V_MIN, V_MIN);
    send_item(OP_MUL,  V_MIN, V_MIN);
    send_item(OP_LOAD, 32'd6, -32'sd4);
    send_item(OP_ADD,  32'd3, 32'd2);
    send_item(OP_MUL,  V_MIN, 32'd1);
    send_item(OP_LOAD, V_MAX, 32'h7fff_fffe);
    send_item(OP_MUL,  V_MAX, 32'h7fff_fffe);
    send_item(OP_LOAD, V_MIN, V_MAX);
    send_item(OP_ADD,  V_MAX, V_MIN);
    send_item(OP_SUB,  V_MIN, V_NEG1);
    send_item(OP_MUL,  V_NEG1, V_NEG1);
    send_item(OP_SUB,  V_MAX, V_MAX);
    wait_drained();

    // random part, with a stretch of no stalls and periodic drains
    for (int sent = 0; sent < RANDOM_ITEMS; sent++) begin
      logic [1:0]  op;
      logic [31:0] nv;
      logic [31:0] dv;
      no_idle = (sent >= 500 && sent < 650);
      if (sent % 350 == 349) wait_drained();
      op = pick_op();
      nv = pick_value(1'b0);
      dv = pick_value(1'b1);
      send_item(op, nv, dv);
    end

    // wind down
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("** rational_accumulator_alu_core: PASSED **");
    else
      $display("** rational_accumulator_alu_core: FAILED **");
    $finish;
  end

endmodule
